FILE: hw/rtl/fbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbe_pkg
// Shared types, widths and codes of the FIR band equalizer.
// ----------------------------------------------------------------------------
package fbe_pkg;

  localparam int DEF_BANDS   = 10;
  localparam int DEF_TAPS    = 64;

  localparam int FUNC_W      = 2;
  localparam int SAMPLE_W    = 16;
  localparam int BAND_IDX_W  = 4;
  localparam int TAP_IDX_W   = 6;
  localparam int COEF_W      = 18;
  localparam int GAIN_W      = 16;
  localparam int OUT_W       = 24;
  localparam int ROUND_SHIFT = 29;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_COEF   = 2'd1,
    FUNC_GAIN   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic sample_wr;
    logic hist_clear;
    logic coef_wr;
    logic gain_wr;
    logic mac_step;
    logic last_tap;
    logic last_band;
    logic load_out;
  } fbe_cmd_t;

  typedef struct packed {
    logic total_done;
    logic out_free;
  } fbe_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fir_band_equalizer.sv
// Load words (coefficient, gain) give no output word. An audio sample runs
// one shared multiply-accumulate step per tap per band, reading one
// coefficient and one history entry a cycle. The input stalls until the
// sample's sum is loaded into the output register; that register holds a
// finished word while the next item is taken. Reset clears the history line.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_band_equalizer
// Graphic equalizer from a bank of FIR filters sharing one history line,
// with per-band gain, summation, rounding and 24-bit saturation.
// ----------------------------------------------------------------------------
module fir_band_equalizer #(
  parameter int BANDS = fbe_pkg::DEF_BANDS,
  parameter int TAPS  = fbe_pkg::DEF_TAPS
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire [fbe_pkg::FUNC_W-1:0]            func_i,
  input  wire                                  start_of_signal_i,
  input  wire signed [fbe_pkg::SAMPLE_W-1:0]   sample_in_i,
  input  wire [fbe_pkg::BAND_IDX_W-1:0]        band_index_i,
  input  wire [fbe_pkg::TAP_IDX_W-1:0]         tap_index_i,
  input  wire signed [fbe_pkg::COEF_W-1:0]     coef_value_i,
  input  wire [fbe_pkg::GAIN_W-1:0]            gain_value_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic signed [fbe_pkg::OUT_W-1:0]     sample_out_o
);
  import fbe_pkg::*;

  fbe_cmd_t    cmd;
  fbe_status_t status;

  fbe_ctrl #(
    .BANDS (BANDS),
    .TAPS  (TAPS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .func_i            (func_i),
    .start_of_signal_i (start_of_signal_i),
    .band_index_i      (band_index_i),
    .tap_index_i       (tap_index_i),
    .status_i          (status),
    .in_stall_o        (in_stall_o),
    .cmd_o             (cmd)
  );

  fbe_datapath #(
    .BANDS (BANDS),
    .TAPS  (TAPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_in_i  (sample_in_i),
    .band_index_i (band_index_i),
    .tap_index_i  (tap_index_i),
    .coef_value_i (coef_value_i),
    .gain_value_i (gain_value_i),
    .out_stall_i  (out_stall_i),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o)
  );

  // An accepted sample puts the block to work at once.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i == FUNC_SAMPLE) |=> in_stall_o)
    else $error("sample accepted but block not busy");

  // The final sum only completes while no new item can be taken.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.total_done |-> in_stall_o)
    else $error("sum completed while block idle");

  // A result is never loaded over a word that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("output word overwritten");

endmodule
`default_nettype wire

FILE: hw/rtl/fbe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbe_ctrl
// Sequencer: takes input words, decodes them and steps the datapath through
// every tap of every band for each audio sample.
// ----------------------------------------------------------------------------
module fbe_ctrl #(
  parameter int BANDS = fbe_pkg::DEF_BANDS,
  parameter int TAPS  = fbe_pkg::DEF_TAPS
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  input  wire [fbe_pkg::FUNC_W-1:0]      func_i,
  input  wire                            start_of_signal_i,
  input  wire [fbe_pkg::BAND_IDX_W-1:0]  band_index_i,
  input  wire [fbe_pkg::TAP_IDX_W-1:0]   tap_index_i,
  input  fbe_pkg::fbe_status_t           status_i,
  output logic                           in_stall_o,
  output fbe_pkg::fbe_cmd_t              cmd_o
);
  import fbe_pkg::*;

  localparam int TAP_CNT_W  = $clog2(TAPS);
  localparam int BAND_CNT_W = (BANDS > 1) ? $clog2(BANDS) : 1;

  ctrl_state_e            state_q, state_d;
  logic [TAP_CNT_W-1:0]   tap_cnt_q, tap_cnt_d;
  logic [BAND_CNT_W-1:0]  band_cnt_q, band_cnt_d;
  logic                   band_ok, tap_ok, last_tap, last_band;

  assign band_ok   = int'(band_index_i) < BANDS;
  assign tap_ok    = int'(tap_index_i) < TAPS;
  assign last_tap  = tap_cnt_q == TAP_CNT_W'(TAPS - 1);
  assign last_band = band_cnt_q == BAND_CNT_W'(BANDS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tap_cnt_q  <= '0;
      band_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      tap_cnt_q  <= tap_cnt_d;
      band_cnt_q <= band_cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    tap_cnt_d  = tap_cnt_q;
    band_cnt_d = band_cnt_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        tap_cnt_d  = '0;
        band_cnt_d = '0;
        if (in_valid_i) begin
          unique case (func_e'(func_i))
            FUNC_SAMPLE: begin
              cmd_o.sample_wr  = 1'b1;
              cmd_o.hist_clear = start_of_signal_i;
              state_d          = ST_RUN;
            end
            FUNC_COEF: cmd_o.coef_wr = band_ok && tap_ok;
            FUNC_GAIN: cmd_o.gain_wr = band_ok;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.mac_step  = 1'b1;
        cmd_o.last_tap  = last_tap;
        cmd_o.last_band = last_band;
        if (last_tap) begin
          tap_cnt_d  = '0;
          band_cnt_d = band_cnt_q + 1'b1;
          if (last_band) begin
            state_d = ST_DRAIN;
          end
        end else begin
          tap_cnt_d = tap_cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status_i.total_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold the finished sum until the output register can take it.
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fbe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbe_datapath
// History line, coefficient and gain stores, the pipelined multiply-
// accumulate chain, band scaling, rounding and the output register.
// ----------------------------------------------------------------------------
module fbe_datapath #(
  parameter int BANDS = fbe_pkg::DEF_BANDS,
  parameter int TAPS  = fbe_pkg::DEF_TAPS
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  fbe_pkg::fbe_cmd_t                    cmd_i,
  input  wire signed [fbe_pkg::SAMPLE_W-1:0]   sample_in_i,
  input  wire [fbe_pkg::BAND_IDX_W-1:0]        band_index_i,
  input  wire [fbe_pkg::TAP_IDX_W-1:0]         tap_index_i,
  input  wire signed [fbe_pkg::COEF_W-1:0]     coef_value_i,
  input  wire [fbe_pkg::GAIN_W-1:0]            gain_value_i,
  input  wire                                  out_stall_i,
  output fbe_pkg::fbe_status_t                 status_o,
  output logic                                 out_valid_o,
  output logic signed [fbe_pkg::OUT_W-1:0]     sample_out_o
);
  import fbe_pkg::*;

  localparam int HP_W       = $clog2(TAPS);
  localparam int DEPTH      = BANDS * TAPS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int BAND_PTR_W = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int MUL_W      = COEF_W + SAMPLE_W;
  localparam int ACC_W      = MUL_W + $clog2(TAPS);
  localparam int BP_W       = ACC_W + GAIN_W + 1;
  localparam int TOT_W      = BP_W + $clog2(BANDS) + 1;
  localparam int RND_W      = TOT_W + 1;
  localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SAT_MIN = -SAT_MAX - RND_W'(1);

  // Stores.
  logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
  logic [TAPS-1:0]            hist_vld_q, hist_vld_d;
  logic signed [COEF_W-1:0]   coef_mem [DEPTH];
  logic [GAIN_W-1:0]          gain_q [BANDS];

  logic [HP_W-1:0]   wr_ptr_q, wr_ptr_next, rd_ptr_q;
  logic [ADDR_W-1:0] caddr_q, coef_wr_addr;

  // Pipeline.
  logic                       s1_v_q, s1_lt_q, s1_lb_q;
  logic signed [SAMPLE_W-1:0] hist_rd_q;
  logic                       hist_rd_vld_q;
  logic signed [COEF_W-1:0]   coef_rd_q;
  logic signed [SAMPLE_W-1:0] hist_eff;
  logic                       s2_v_q, s2_lt_q, s2_lb_q;
  logic signed [MUL_W-1:0]    mul_q;
  logic signed [ACC_W-1:0]    acc_q, acc_sum;
  logic                       bs_v_q, bs_lb_q;
  logic signed [ACC_W-1:0]    band_sum_q;
  logic [BAND_PTR_W-1:0]      band_ptr_q;
  logic                       bp_v_q, bp_lb_q;
  logic signed [BP_W-1:0]     band_prod_q;
  logic signed [TOT_W-1:0]    total_q;
  logic                       done_q;

  logic signed [RND_W-1:0]    rnd_sum, rnd_shift;
  logic signed [OUT_W-1:0]    sat_val;

  assign wr_ptr_next  = (wr_ptr_q == HP_W'(TAPS - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign coef_wr_addr = ADDR_W'(band_index_i) * ADDR_W'(TAPS) + ADDR_W'(tap_index_i);

  // The history is a ring: the newest sample sits at the write pointer and
  // older ones follow at descending addresses. Cleared entries read as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_wr) begin
      hist_mem[wr_ptr_next] <= sample_in_i;
    end
    hist_rd_q <= hist_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr) begin
      coef_mem[coef_wr_addr] <= coef_value_i;
    end
    coef_rd_q <= coef_mem[caddr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain_wr) begin
      gain_q[band_index_i[BAND_PTR_W-1:0]] <= gain_value_i;
    end
  end

  always_comb begin
    hist_vld_d = cmd_i.hist_clear ? '0 : hist_vld_q;
    hist_vld_d[wr_ptr_next] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q    <= '0;
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      caddr_q       <= '0;
      hist_rd_vld_q <= 1'b0;
    end else begin
      hist_rd_vld_q <= hist_vld_q[rd_ptr_q];
      if (cmd_i.sample_wr) begin
        wr_ptr_q   <= wr_ptr_next;
        rd_ptr_q   <= wr_ptr_next;
        caddr_q    <= '0;
        hist_vld_q <= hist_vld_d;
      end else if (cmd_i.mac_step) begin
        caddr_q <= caddr_q + 1'b1;
        if (cmd_i.last_tap) begin
          rd_ptr_q <= wr_ptr_q;
        end else begin
          rd_ptr_q <= (rd_ptr_q == '0) ? HP_W'(TAPS - 1) : rd_ptr_q - 1'b1;
        end
      end
    end
  end

  assign hist_eff = hist_rd_vld_q ? hist_rd_q : '0;
  assign acc_sum  = acc_q + ACC_W'(mul_q);

  always_ff @(posedge clk_i) begin
    mul_q       <= coef_rd_q * hist_eff;
    band_prod_q <= band_sum_q * $signed({1'b0, gain_q[band_ptr_q]});
    if (s2_v_q && s2_lt_q) begin
      band_sum_q <= acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_lt_q    <= 1'b0;
      s1_lb_q    <= 1'b0;
      s2_v_q     <= 1'b0;
      s2_lt_q    <= 1'b0;
      s2_lb_q    <= 1'b0;
      bs_v_q     <= 1'b0;
      bs_lb_q    <= 1'b0;
      bp_v_q     <= 1'b0;
      bp_lb_q    <= 1'b0;
      band_ptr_q <= '0;
      acc_q      <= '0;
      total_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      s1_v_q  <= cmd_i.mac_step;
      s1_lt_q <= cmd_i.last_tap;
      s1_lb_q <= cmd_i.last_band;
      s2_v_q  <= s1_v_q;
      s2_lt_q <= s1_lt_q;
      s2_lb_q <= s1_lb_q;
      bs_v_q  <= s2_v_q && s2_lt_q;
      bs_lb_q <= s2_lb_q;
      bp_v_q  <= bs_v_q;
      bp_lb_q <= bs_lb_q;
      done_q  <= bp_v_q && bp_lb_q;
      if (cmd_i.sample_wr) begin
        acc_q      <= '0;
        total_q    <= '0;
        band_ptr_q <= '0;
      end else begin
        if (s2_v_q) begin
          acc_q <= s2_lt_q ? '0 : acc_sum;
        end
        if (bs_v_q) begin
          band_ptr_q <= (band_ptr_q == BAND_PTR_W'(BANDS - 1)) ? '0 : band_ptr_q + 1'b1;
        end
        if (bp_v_q) begin
          total_q <= total_q + TOT_W'(band_prod_q);
        end
      end
    end
  end

  // Round half up, then saturate to the output range.
  assign rnd_sum   = RND_W'(total_q) + (RND_W'(1) <<< (ROUND_SHIFT - 1));
  assign rnd_shift = rnd_sum >>> ROUND_SHIFT;

  always_comb begin
    if (rnd_shift > SAT_MAX) begin
      sat_val = OUT_W'(SAT_MAX);
    end else if (rnd_shift < SAT_MIN) begin
      sat_val = OUT_W'(SAT_MIN);
    end else begin
      sat_val = OUT_W'(rnd_shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_out_o <= sat_val;
    end
  end

  assign status_o.total_done = done_q;
  assign status_o.out_free   = !out_valid_o || !out_stall_i;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fir_band_equalizer. Coefficient, gain and audio
// words are sent with random gaps while the output side stalls at random.
// A behavioral model of the filter bank predicts each output word, and every
// output word is compared in order against that prediction.
// ----------------------------------------------------------------------------
module tb;
  import fbe_pkg::*;

  localparam int BANDS         = DEF_BANDS;
  localparam int TAPS          = DEF_TAPS;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = BANDS * TAPS + 60;
  localparam int HOLD_CYCLES   = 3000;

  localparam logic [FUNC_W-1:0]            FUNC_RESERVED = 2'd3;
  localparam logic [BAND_IDX_W-1:0]        BAND_TOP      = 4'd15;
  localparam logic signed [SAMPLE_W-1:0]   SMP_MAX       = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0]   SMP_MIN       = 16'sh8000;
  localparam logic signed [COEF_W-1:0]     COEF_MAX      = 18'sh1ffff;
  localparam logic signed [COEF_W-1:0]     COEF_MIN      = 18'sh20000;
  localparam logic signed [COEF_W-1:0]     COEF_EIGHTH   = 18'sd16384;
  localparam logic [GAIN_W-1:0]            GAIN_MAX      = 16'hffff;
  localparam logic [GAIN_W-1:0]            GAIN_UNITY    = 16'h1000;
  localparam longint                       OUT_MAX       = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint                       OUT_MIN       = -(64'sd1 <<< (OUT_W - 1));

  logic                         clk_i             = 1'b0;
  logic                         rst_ni            = 1'b0;
  logic                         in_valid_i        = 1'b0;
  logic                         in_stall_o;
  logic [FUNC_W-1:0]            func_i            = FUNC_SAMPLE;
  logic                         start_of_signal_i = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_in_i       = '0;
  logic [BAND_IDX_W-1:0]        band_index_i      = '0;
  logic [TAP_IDX_W-1:0]         tap_index_i       = '0;
  logic signed [COEF_W-1:0]     coef_value_i      = '0;
  logic [GAIN_W-1:0]            gain_value_i      = '0;
  logic                         out_valid_o;
  logic                         out_stall_i       = 1'b0;
  logic signed [OUT_W-1:0]      sample_out_o;

  // Model of the filter bank state.
  logic signed [SAMPLE_W-1:0]   mdl_hist [TAPS] = '{default: '0};
  logic signed [COEF_W-1:0]     mdl_coef [BANDS][TAPS];
  logic [GAIN_W-1:0]            mdl_gain [BANDS];
  logic signed [OUT_W-1:0]      eq_out_q [$];
  logic signed [OUT_W-1:0]      eq_want;

  int err_count    = 0;
  int cycle_cnt    = 0;
  int out_hold_req = 0;
  int hold_left    = 0;
  int wait_left    = 0;
  bit no_idle      = 1'b0;

  fir_band_equalizer #(
    .BANDS(BANDS),
    .TAPS (TAPS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .start_of_signal_i(start_of_signal_i),
    .sample_in_i      (sample_in_i),
    .band_index_i     (band_index_i),
    .tap_index_i      (tap_index_i),
    .coef_value_i     (coef_value_i),
    .gain_value_i     (gain_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_out_o     (sample_out_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_count++;
  endtask

  // Exact bank sum, then round half up from Q.29 and saturate to 24 bits.
  function automatic logic signed [OUT_W-1:0] equalized_sample();
    longint total;
    longint acc;
    longint rounded;
    int     b;
    int     k;
    total = 0;
    for (b = 0; b < BANDS; b++) begin
      acc = 0;
      for (k = 0; k < TAPS; k++) begin
        acc += longint'(mdl_coef[b][k]) * longint'(mdl_hist[k]);
      end
      total += acc * longint'(mdl_gain[b]);
    end
    rounded = (total + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (rounded > OUT_MAX) begin
      rounded = OUT_MAX;
    end else if (rounded < OUT_MIN) begin
      rounded = OUT_MIN;
    end
    return rounded[OUT_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] kind, input logic sos,
                           input logic signed [SAMPLE_W-1:0] smp,
                           input logic [BAND_IDX_W-1:0] band,
                           input logic [TAP_IDX_W-1:0] tap,
                           input logic signed [COEF_W-1:0] coef,
                           input logic [GAIN_W-1:0] gain);
    int gap;
    int k;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    func_i            <= kind;
    start_of_signal_i <= sos;
    sample_in_i       <= smp;
    band_index_i      <= band;
    tap_index_i       <= tap;
    coef_value_i      <= coef;
    gain_value_i      <= gain;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // The word was taken at this edge, so the model moves on with it.
    case (kind)
      FUNC_SAMPLE: begin
        if (sos) begin
          for (k = 0; k < TAPS; k++) mdl_hist[k] = '0;
        end
        for (k = TAPS - 1; k > 0; k--) mdl_hist[k] = mdl_hist[k-1];
        mdl_hist[0] = smp;
        eq_out_q.push_back(equalized_sample());
      end
      FUNC_COEF: begin
        if (band < BANDS && tap < TAPS) mdl_coef[band][tap] = coef;
      end
      FUNC_GAIN: begin
        if (band < BANDS) mdl_gain[band] = gain;
      end
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic sos, input logic signed [SAMPLE_W-1:0] smp);
    send_word(FUNC_SAMPLE, sos, smp, BAND_IDX_W'($urandom), TAP_IDX_W'($urandom),
              COEF_W'($urandom), GAIN_W'($urandom));
  endtask

  task automatic send_coef(input logic [BAND_IDX_W-1:0] band,
                           input logic [TAP_IDX_W-1:0] tap,
                           input logic signed [COEF_W-1:0] coef);
    send_word(FUNC_COEF, 1'($urandom), SAMPLE_W'($urandom), band, tap, coef,
              GAIN_W'($urandom));
  endtask

  task automatic send_gain(input logic [BAND_IDX_W-1:0] band, input logic [GAIN_W-1:0] gain);
    send_word(FUNC_GAIN, 1'($urandom), SAMPLE_W'($urandom), band, TAP_IDX_W'($urandom),
              COEF_W'($urandom), gain);
  endtask

  task automatic send_reserved();
    send_word(FUNC_RESERVED, 1'($urandom), SAMPLE_W'($urandom), BAND_IDX_W'($urandom),
              TAP_IDX_W'($urandom), COEF_W'($urandom), GAIN_W'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (eq_out_q.size() != 0) @(posedge clk_i);
  endtask

  // Every coefficient is written before the first sample. Bands 0-3 are
  // full-scale positive so that, with full-scale samples of either sign, both
  // saturation limits can be reached with a few samples; bands 4-5 are full-scale negative.
  task automatic test_load_coefficients();
    logic signed [COEF_W-1:0] c;
    int b;
    int k;
    for (b = 0; b < BANDS; b++) begin
      for (k = 0; k < TAPS; k++) begin
        if (b < 4) begin
          c = COEF_MAX;
        end else if (b < 6) begin
          c = COEF_MIN;
        end else begin
          c = COEF_W'($urandom);
        end
        send_coef(BAND_IDX_W'(b), TAP_IDX_W'(k), c);
      end
    end
  endtask

  task automatic test_saturation();
    int b;
    int k;
    for (b = 0; b < BANDS; b++) send_gain(BAND_IDX_W'(b), (b < 4) ? GAIN_MAX : '0);
    for (k = 0; k < 5; k++) send_sample(k == 0, SMP_MAX);
    for (k = 0; k < 5; k++) send_sample(k == 0, SMP_MIN);
  endtask

  // Only band 6 tap 0 contributes, at 1/8 with unity gain, so a fresh
  // history of s gives s/8 and lands on exact halves for s = 4 and 12.
  task automatic test_rounding_and_ignored();
    int b;
    for (b = 0; b < 4; b++) send_gain(BAND_IDX_W'(b), '0);
    send_gain(4'd6, GAIN_UNITY);
    send_coef(4'd6, 6'd0, COEF_EIGHTH);
    send_reserved();
    send_coef(BAND_IDX_W'(BANDS), 6'd0, COEF_MAX);
    send_gain(BAND_TOP, GAIN_MAX);
    send_sample(1'b1, 16'sd12);
    send_sample(1'b1, -16'sd12);
    send_sample(1'b1, 16'sd4);
    send_sample(1'b1, -16'sd4);
    send_sample(1'b1, '0);
  endtask

  // The output side holds off long enough that the block fills and stalls
  // its input while more samples are offered.
  task automatic test_backpressure();
    int k;
    out_hold_req = HOLD_CYCLES;
    for (k = 0; k < 6; k++) send_sample($urandom_range(0, 3) == 0, pick_sample());
    wait_drained();
  endtask

  task automatic test_random_mix(input int n);
    logic [BAND_IDX_W-1:0]    band;
    logic signed [COEF_W-1:0] c;
    logic [GAIN_W-1:0]        g;
    int                       i;
    int                       sel;
    for (i = 0; i < n; i++) begin
      // One stretch in three runs without gaps or stalls.
      no_idle = (i % 120) >= 80;
      sel = $urandom_range(0, 99);
      band = ($urandom_range(0, 9) == 0) ? BAND_IDX_W'($urandom_range(BANDS, 15))
                                         : BAND_IDX_W'($urandom_range(0, BANDS - 1));
      if (sel < 50) begin
        send_sample($urandom_range(0, 19) == 0, pick_sample());
      end else if (sel < 75) begin
        case ($urandom_range(0, 9))
          0:       c = COEF_MAX;
          1:       c = COEF_MIN;
          default: c = COEF_W'($urandom);
        endcase
        send_coef(band, TAP_IDX_W'($urandom), c);
      end else if (sel < 92) begin
        case ($urandom_range(0, 9))
          0:       g = '0;
          1:       g = GAIN_MAX;
          2:       g = GAIN_UNITY;
          default: g = GAIN_W'($urandom);
        endcase
        send_gain(band, g);
      end else begin
        send_reserved();
      end
    end
    no_idle = 1'b0;
  endtask

  // Output stall: a drawn number of valid cycles is stalled before each
  // word, plus a long hold when a test requests one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_hold_req > 0) begin
        hold_left = out_hold_req;
        out_hold_req = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      if (out_valid_o && !out_stall_i) begin
        wait_left = no_idle ? 0 : $urandom_range(0, 3);
      end else if (out_valid_o && wait_left > 0) begin
        wait_left--;
      end
      out_stall_i <= (hold_left > 0) || (wait_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (eq_out_q.size() == 0) begin
        report_error($sformatf("output word %0d with none expected", sample_out_o));
      end else begin
        eq_want = eq_out_q.pop_front();
        if (sample_out_o !== eq_want) begin
          report_error($sformatf("sample_out got %0d expected %0d", sample_out_o, eq_want));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d output words outstanding", eq_out_q.size());
      $display("FAIL fir_band_equalizer");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_load_coefficients();
    test_saturation();
    test_rounding_and_ignored();
    test_backpressure();
    test_random_mix(240);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS fir_band_equalizer");
    end else begin
      $display("FAIL fir_band_equalizer");
    end
    $finish;
  end

endmodule
